// ===== hw/rtl/ljpf_pkg.sv =====
// shared types, sizes and fixed-point constants for the lennard-jones step block
package ljpf_pkg;

    // particle store sizing
    localparam int MAX_P = 64;
    localparam int IDX_W = $clog2(MAX_P);
    localparam int CNT_W = IDX_W + 1;

    // arithmetic unit widths
    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int ROOT_W = 32;

    // unsigned q32.32 constants
    localparam logic [63:0] Q32_CAP    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] RC2_Q32    = 64'd25 << 30;
    localparam logic [63:0] FSHIFT_Q32 = (64'd46491 << 42) / 64'd1220703125;
    localparam logic [63:0] KLIM24     = Q32_CAP / 64'd24;
    localparam logic [63:0] KLIM48     = Q32_CAP / 64'd48;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 2'd1;
    localparam logic [30:0] BOX_RESET = 31'd1310720;
    localparam logic [30:0] DT_RESET  = 31'd655;

    // input item
    typedef struct packed {
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] vel_x_in;
        logic signed [31:0] vel_y_in;
        logic               last_in;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [5:0]         particle_index;
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic               last_out;
    } out_item_t;

endpackage

// ===== hw/rtl/ljpf_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module ljpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ljpf_mul.sv =====
// 64x64 unsigned multiplier built from four sequential 32x32 partial products
module ljpf_mul
    import ljpf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [WORD_W-1:0]   a,
    input  logic [WORD_W-1:0]   b,
    output logic                done,
    output logic [2*WORD_W-1:0] prod
);

    logic                busy_reg;
    logic                done_reg;
    logic [2:0]          step_reg;
    logic [WORD_W-1:0]   a_reg;
    logic [WORD_W-1:0]   b_reg;
    logic [WORD_W-1:0]   pp_reg;
    logic [2*WORD_W-1:0] acc_reg;
    logic [HALF_W-1:0]   a_half;
    logic [HALF_W-1:0]   b_half;
    logic [2*WORD_W-1:0] pp_shifted;

    // half selection: lo*lo, lo*hi, hi*lo, hi*hi
    assign a_half = step_reg[1] ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_half = step_reg[0] ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];

    // align the previous partial product
    always_comb
    begin
        case (step_reg)
            3'd1:    pp_shifted = {{WORD_W{1'b0}}, pp_reg};
            3'd2,
            3'd3:    pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            3'd4:    pp_shifted = {pp_reg, {WORD_W{1'b0}}};
            default: pp_shifted = '0;
        endcase
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands, partial product and accumulator
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg  <= a_half * b_half;
            acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hw/rtl/ljpf_div.sv =====
// 64-bit unsigned restoring divider, one quotient bit per cycle
module ljpf_div
    import ljpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    localparam int CW = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dsr_reg;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_sub;
    logic              fits;

    // one restoring step
    assign rem_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[WORD_W-1:0] : rem_shift[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/ljpf_sqrt.sv =====
// 64-bit integer square root, one result bit per cycle
module ljpf_sqrt
    import ljpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] rad,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CW = $clog2(ROOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [WORD_W-1:0] v_reg;
    logic [WORD_W-1:0] res_reg;
    logic [WORD_W-1:0] bit_reg;
    logic [WORD_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // digit-by-digit root
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            v_reg   <= rad;
            res_reg <= '0;
            bit_reg <= {2'b01, {(WORD_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== hw/rtl/lj_pair_force_leapfrog_step.sv =====
// top level: particle stores, pair force sequencer and leapfrog integrator
//
// Particles load one per item into position and velocity rams (64 entries);
// loads past the store depth are dropped. An item with last_in set starts
// the step, during which no item is accepted. Each ordered pair inside the
// cutoff runs two divisions on the shared 64-bit divider, a square root and
// nine multiplies on one shared multiplier; a pair beyond cutoff or at zero
// distance adds no force. After all accelerations are in the accel ram, each
// particle is integrated and then held on the output until taken, in load
// order. A step over N particles thus costs roughly N*(N-1) pair evaluations.
// Stores need no clearing after reset.
module lj_pair_force_leapfrog_step
    import ljpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [4:0] {
        S_LOAD, S_RD_I, S_LD_I, S_RD_J, S_MI, S_SQX, S_SQY, S_CHK, S_DIVW,
        S_W2, S_W3, S_W4, S_W7, S_SQRT, S_DIVR, S_SH, S_G, S_FX, S_FY, S_ACC,
        S_NEXT_J, S_WR_A, S_IR, S_IL, S_IAX, S_IAY, S_IVX, S_IVY, S_IWR, S_OUT
    } state_t;

    // saturate a signed value to q16.16
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [63:0] cap62(input logic [63:0] v);
        return (v > Q32_CAP) ? Q32_CAP : v;
    endfunction

    // high product bits in q32.32, capped
    function automatic logic [63:0] qsat(input logic [127:0] p);
        return (p[127:32] > {32'd0, Q32_CAP}) ? Q32_CAP : p[95:32];
    endfunction

    function automatic logic [63:0] mag32(input logic signed [31:0] v);
        logic signed [32:0] e;
        e = 33'(v);
        return e[32] ? 64'(-e) : 64'(e);
    endfunction

    // minimum image with a single box shift, then negated direction
    function automatic logic signed [31:0] mimg(input logic signed [31:0] a0,
                                                input logic signed [31:0] a1,
                                                input logic [30:0] len);
        logic signed [34:0] dd;
        logic signed [34:0] len35;
        logic signed [34:0] tw;
        logic signed [34:0] adj;
        dd    = 35'(a1) - 35'(a0);
        len35 = $signed({4'b0000, len});
        tw    = dd <<< 1;
        if (tw > len35)
            adj = dd - len35;
        else if (-tw >= len35)
            adj = dd + len35;
        else
            adj = dd;
        return sat32(64'(-adj));
    endfunction

    // signed force component from |d|*|g| >> 32
    function automatic logic signed [31:0] scale(input logic signed [31:0] d,
                                                 input logic gneg,
                                                 input logic [127:0] p);
        logic [63:0] m;
        m = p[95:32];
        if (d[31] != gneg)
            return (m > 64'd2147483648) ? 32'sh8000_0000 : 32'(64'd0 - m);
        else
            return (m > 64'd2147483647) ? 32'sh7FFF_FFFF : m[31:0];
    endfunction

    // v + trunc0(a*dt >> 16), saturated
    function automatic logic signed [31:0] sdt(input logic signed [31:0] v,
                                               input logic signed [31:0] a,
                                               input logic [127:0] p);
        logic signed [63:0] mag;
        logic signed [63:0] delta;
        mag   = $signed(64'(p[63:16]));
        delta = a[31] ? -mag : mag;
        return sat32(64'(v) + delta);
    endfunction

    state_t state_reg;
    logic                 wait_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     j_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    logic [30:0]          box_reg;
    logic [30:0]          dt_reg;

    logic signed [31:0]   pix_reg, piy_reg;
    logic signed [31:0]   dx_reg, dy_reg;
    logic [63:0]          sq_reg, r2_reg;
    logic [63:0]          w_reg, w2_reg, w3_reg, w4_reg, w7_reg;
    logic [ROOT_W-1:0]    s_reg;
    logic [63:0]          invr_reg, sh_reg;
    logic signed [63:0]   g_reg;
    logic signed [31:0]   fx_reg, fy_reg, sx_reg, sy_reg;
    logic signed [31:0]   vx_reg, vy_reg, ax_reg, ay_reg, px_reg, py_reg;

    logic                 in_acc;
    logic                 room;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 is_op;
    logic                 use_mul, use_div, use_sqrt;
    state_t               op_next;
    logic                 op_done;
    logic                 cap;
    logic                 pair_skip;
    logic                 last_i;

    logic [63:0]          mul_a, mul_b;
    logic                 mul_done;
    logic [127:0]         mul_prod;
    logic [63:0]          div_n, div_d, div_q;
    logic                 div_done;
    logic [ROOT_W-1:0]    sqrt_root;
    logic                 sqrt_done;

    logic                 pos_we, vel_we, acc_we;
    logic [IDX_W-1:0]     waddr, pos_raddr;
    logic [63:0]          pos_wdata, vel_wdata;
    logic [63:0]          pos_rd, vel_rd, acc_rd;

    logic [63:0]          ka, kb, bt, gmag;
    logic signed [63:0]   g_comb;

    // handshake and load bookkeeping
    assign in_ready  = (state_reg == S_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign room      = cnt_reg < CNT_W'(MAX_P);
    assign cnt_inc   = room ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign last_i    = (i_reg + CNT_W'(1)) == n_reg;
    assign pair_skip = (r2_reg == 64'd0) || (r2_reg > RC2_Q32);

    // unit ops: which unit and the state that follows
    always_comb
    begin
        is_op    = 1'b1;
        use_mul  = 1'b0;
        use_div  = 1'b0;
        use_sqrt = 1'b0;
        op_next  = S_LOAD;
        unique case (state_reg) inside
            S_SQX:   begin use_mul = 1'b1;  op_next = S_SQY;  end
            S_SQY:   begin use_mul = 1'b1;  op_next = S_CHK;  end
            S_DIVW:  begin use_div = 1'b1;  op_next = S_W2;   end
            S_W2:    begin use_mul = 1'b1;  op_next = S_W3;   end
            S_W3:    begin use_mul = 1'b1;  op_next = S_W4;   end
            S_W4:    begin use_mul = 1'b1;  op_next = S_W7;   end
            S_W7:    begin use_mul = 1'b1;  op_next = S_SQRT; end
            S_SQRT:  begin use_sqrt = 1'b1; op_next = S_DIVR; end
            S_DIVR:  begin use_div = 1'b1;  op_next = S_SH;   end
            S_SH:    begin use_mul = 1'b1;  op_next = S_G;    end
            S_FX:    begin use_mul = 1'b1;  op_next = S_FY;   end
            S_FY:    begin use_mul = 1'b1;  op_next = S_ACC;  end
            S_IAX:   begin use_mul = 1'b1;  op_next = S_IAY;  end
            S_IAY:   begin use_mul = 1'b1;  op_next = S_IVX;  end
            S_IVX:   begin use_mul = 1'b1;  op_next = S_IVY;  end
            S_IVY:   begin use_mul = 1'b1;  op_next = S_IWR;  end
            default: is_op = 1'b0;
        endcase
    end

    assign op_done = (use_mul && mul_done) || (use_div && div_done)
                   || (use_sqrt && sqrt_done);
    assign cap     = wait_reg && op_done;

    // multiplier operands
    assign gmag = g_reg[63] ? 64'(-g_reg) : 64'(g_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX:   begin mul_a = mag32(dx_reg); mul_b = mag32(dx_reg); end
            S_SQY:   begin mul_a = mag32(dy_reg); mul_b = mag32(dy_reg); end
            S_W2:    begin mul_a = w_reg;         mul_b = w_reg;         end
            S_W3:    begin mul_a = w2_reg;        mul_b = w_reg;         end
            S_W4:    begin mul_a = w2_reg;        mul_b = w2_reg;        end
            S_W7:    begin mul_a = w4_reg;        mul_b = w3_reg;        end
            S_SH:    begin mul_a = FSHIFT_Q32;    mul_b = invr_reg;      end
            S_FX:    begin mul_a = mag32(dx_reg); mul_b = gmag;          end
            S_FY:    begin mul_a = mag32(dy_reg); mul_b = gmag;          end
            S_IAX:   begin mul_a = mag32(ax_reg); mul_b = 64'(dt_reg);   end
            S_IAY:   begin mul_a = mag32(ay_reg); mul_b = 64'(dt_reg);   end
            S_IVX:   begin mul_a = mag32(vx_reg); mul_b = 64'(dt_reg);   end
            S_IVY:   begin mul_a = mag32(vy_reg); mul_b = 64'(dt_reg);   end
            default: ;
        endcase
    end

    // divider operands: 1/r2 scaled, then inverse distance
    assign div_n = (state_reg == S_DIVR) ? Q32_CAP : ALL_ONES;
    assign div_d = (state_reg == S_DIVR) ? 64'(s_reg) : r2_reg;

    // force magnitude term from the powers of 1/r2 and the shift term
    assign ka     = (w4_reg > KLIM24) ? Q32_CAP : (w4_reg << 4) + (w4_reg << 3);
    assign kb     = (w7_reg > KLIM48) ? Q32_CAP : (w7_reg << 5) + (w7_reg << 4);
    assign bt     = cap62(kb + sh_reg);
    assign g_comb = $signed(ka) - $signed(bt);

    ljpf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (use_mul && !wait_reg),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ljpf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (use_div && !wait_reg),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    ljpf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (use_sqrt && !wait_reg),
        .rad   (r2_reg << 28),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // store ports
    assign pos_we    = (in_acc && room) || (state_reg == S_IWR);
    assign vel_we    = pos_we;
    assign acc_we    = (state_reg == S_WR_A);
    assign waddr     = (state_reg == S_LOAD) ? cnt_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign pos_raddr = (state_reg == S_RD_J) ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign pos_wdata = (state_reg == S_LOAD) ? {in_item.pos_x_in, in_item.pos_y_in}
                                             : {px_reg, py_reg};
    assign vel_wdata = (state_reg == S_LOAD) ? {in_item.vel_x_in, in_item.vel_y_in}
                                             : {vx_reg, vy_reg};

    ljpf_ram #(.WIDTH(64), .DEPTH(MAX_P)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rd)
    );

    ljpf_ram #(.WIDTH(64), .DEPTH(MAX_P)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (waddr),
        .wdata (vel_wdata),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (vel_rd)
    );

    ljpf_ram #(.WIDTH(64), .DEPTH(MAX_P)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (i_reg[IDX_W-1:0]),
        .wdata ({sx_reg, sy_reg}),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (acc_rd)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= BOX_RESET;
            dt_reg  <= DT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BOX_LENGTH: box_reg <= cfg_data[30:0];
                CFG_TIME_STEP:  dt_reg  <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            wait_reg      <= 1'b0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (is_op)
        begin
            if (!wait_reg)
            begin
                wait_reg <= 1'b1;
            end
            else if (op_done)
            begin
                wait_reg  <= 1'b0;
                state_reg <= op_next;
            end
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        cnt_reg <= cnt_inc;
                        if (in_item.last_in)
                        begin
                            n_reg     <= cnt_inc;
                            i_reg     <= '0;
                            state_reg <= S_RD_I;
                        end
                    end
                end
                S_RD_I:   state_reg <= S_LD_I;
                S_LD_I:
                begin
                    j_reg     <= '0;
                    state_reg <= S_RD_J;
                end
                S_RD_J:   state_reg <= (j_reg == i_reg) ? S_NEXT_J : S_MI;
                S_MI:     state_reg <= S_SQX;
                S_CHK:    state_reg <= pair_skip ? S_ACC : S_DIVW;
                S_G:      state_reg <= S_FX;
                S_ACC:    state_reg <= S_NEXT_J;
                S_NEXT_J:
                begin
                    if ((j_reg + CNT_W'(1)) == n_reg)
                    begin
                        state_reg <= S_WR_A;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= S_RD_J;
                    end
                end
                S_WR_A:
                begin
                    if (last_i)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_IR;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_RD_I;
                    end
                end
                S_IR:     state_reg <= S_IL;
                S_IL:     state_reg <= S_IAX;
                S_IWR:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_i)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + CNT_W'(1);
                            state_reg <= S_IR;
                        end
                    end
                end
                default:  state_reg <= S_LOAD;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LD_I:
            begin
                pix_reg <= pos_rd[63:32];
                piy_reg <= pos_rd[31:0];
                sx_reg  <= '0;
                sy_reg  <= '0;
            end
            S_MI:
            begin
                dx_reg <= mimg(pix_reg, pos_rd[63:32], box_reg);
                dy_reg <= mimg(piy_reg, pos_rd[31:0], box_reg);
            end
            S_SQX:  if (cap) sq_reg <= mul_prod[63:0];
            S_SQY:  if (cap) r2_reg <= sq_reg + mul_prod[63:0];
            S_CHK:
            begin
                fx_reg <= '0;
                fy_reg <= '0;
            end
            S_DIVW: if (cap) w_reg <= cap62(div_q);
            S_W2:   if (cap) w2_reg <= qsat(mul_prod);
            S_W3:   if (cap) w3_reg <= qsat(mul_prod);
            S_W4:   if (cap) w4_reg <= qsat(mul_prod);
            S_W7:   if (cap) w7_reg <= qsat(mul_prod);
            S_SQRT: if (cap) s_reg <= sqrt_root;
            S_DIVR: if (cap) invr_reg <= div_q;
            S_SH:   if (cap) sh_reg <= qsat(mul_prod);
            S_G:    g_reg <= g_comb;
            S_FX:   if (cap) fx_reg <= scale(dx_reg, g_reg[63], mul_prod);
            S_FY:   if (cap) fy_reg <= scale(dy_reg, g_reg[63], mul_prod);
            S_ACC:
            begin
                sx_reg <= sat32(64'(sx_reg) + 64'(fx_reg));
                sy_reg <= sat32(64'(sy_reg) + 64'(fy_reg));
            end
            S_IL:
            begin
                vx_reg <= vel_rd[63:32];
                vy_reg <= vel_rd[31:0];
                ax_reg <= acc_rd[63:32];
                ay_reg <= acc_rd[31:0];
                px_reg <= pos_rd[63:32];
                py_reg <= pos_rd[31:0];
            end
            S_IAX:  if (cap) vx_reg <= sdt(vx_reg, ax_reg, mul_prod);
            S_IAY:  if (cap) vy_reg <= sdt(vy_reg, ay_reg, mul_prod);
            S_IVX:  if (cap) px_reg <= sdt(px_reg, vx_reg, mul_prod);
            S_IVY:  if (cap) py_reg <= sdt(py_reg, vy_reg, mul_prod);
            S_IWR:
            begin
                out_item_reg.particle_index <= 6'(i_reg);
                out_item_reg.pos_x_out      <= px_reg;
                out_item_reg.pos_y_out      <= py_reg;
                out_item_reg.vel_x_out      <= vx_reg;
                out_item_reg.vel_y_out      <= vy_reg;
                out_item_reg.last_out       <= last_i;
            end
            default: ;
        endcase
    end

endmodule

// ===== tb/sv/lj_pair_force_leapfrog_step_tb.sv =====
// testbench for the lennard-jones leapfrog step block: bit-exact prediction and checking
`timescale 1ns / 1ps

module lj_pair_force_leapfrog_step_tb;
    import ljpf_pkg::*;

    localparam int          STORE_DEPTH = 64;
    localparam longint      CYCLE_LIMIT = 4000000;
    localparam int          SETTLE      = 80;
    localparam int          ONE         = 65536;
    localparam longint unsigned CAP62   = 64'h4000_0000_0000_0000;
    localparam longint unsigned CUT2    = 64'd25 << 30;
    localparam longint unsigned SHIFT_K = (64'd46491 << 42) / 64'd1220703125;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    lj_pair_force_leapfrog_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // predictor state
    longint          pos_mem [STORE_DEPTH][2];
    longint          vel_mem [STORE_DEPTH][2];
    longint          acc_mem [STORE_DEPTH][2];
    int              loaded;
    longint unsigned box_len;
    longint unsigned dt;

    out_item_t       pending_particles[$];
    int              error_count;
    int              in_count;
    int              out_count;
    int              cfg_count;
    int              step_count;
    longint          cycle_count = 0;
    bit              calm;

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned cap_q32(longint unsigned v);
        return (v > CAP62) ? CAP62 : v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // (a*b) >> 32, saturated to 64 bits
    function automatic longint unsigned mul_hi(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        if (p[127:96] != 0)
            return '1;
        return p[95:32];
    endfunction

    function automatic longint unsigned mul_q32(longint unsigned a, longint unsigned b);
        return cap_q32(mul_hi(a, b));
    endfunction

    function automatic longint unsigned mul_const(longint unsigned x, longint unsigned k);
        return (x > CAP62 / k) ? CAP62 : x * k;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b   = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // minimum image separation, single shift, negated and saturated
    function automatic longint wrap_sep(longint a0, longint a1);
        longint len;
        longint dd;
        len = longint'(box_len);
        dd  = a1 - a0;
        if (2 * dd > len)
            dd = dd - len;
        else if (-2 * dd >= len)
            dd = dd + len;
        return sat_q16(-dd);
    endfunction

    function automatic longint scale_by_g(longint d, longint g);
        longint unsigned m;
        bit neg;
        m   = mul_hi(magnitude(d), magnitude(g));
        neg = (d < 0) != (g < 0);
        if (neg)
            return (m > 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
        return (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
    endfunction

    function automatic longint scale_by_dt(longint a);
        longint unsigned p;
        p = (magnitude(a) * dt) >> 16;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    // shifted-force lennard-jones pull on particle i from particle j
    task automatic pair_pull(input int i, input int j, output longint fx, output longint fy);
        longint dx, dy, g;
        longint unsigned r2, w, w2, w3, w4, w7, inv_r, ta, tb;
        dx = wrap_sep(pos_mem[i][0], pos_mem[j][0]);
        dy = wrap_sep(pos_mem[i][1], pos_mem[j][1]);
        r2 = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
        fx = 0;
        fy = 0;
        if (r2 == 0 || r2 > CUT2)
            return;
        w     = cap_q32(64'hFFFF_FFFF_FFFF_FFFF / r2);
        w2    = mul_q32(w, w);
        w3    = mul_q32(w2, w);
        w4    = mul_q32(w2, w2);
        w7    = mul_q32(w4, w3);
        inv_r = CAP62 / int_sqrt(r2 << 28);
        ta    = mul_const(w4, 24);
        tb    = cap_q32(mul_const(w7, 48) + mul_q32(SHIFT_K, inv_r));
        g     = longint'(ta) - longint'(tb);
        fx    = scale_by_g(dx, g);
        fy    = scale_by_g(dy, g);
    endtask

    // load one particle; on the last one run the step and queue every particle
    task automatic advance_particles(input in_item_t it);
        longint sx, sy, fx, fy;
        out_item_t r;
        if (loaded < STORE_DEPTH)
        begin
            pos_mem[loaded][0] = longint'(it.pos_x_in);
            pos_mem[loaded][1] = longint'(it.pos_y_in);
            vel_mem[loaded][0] = longint'(it.vel_x_in);
            vel_mem[loaded][1] = longint'(it.vel_y_in);
            loaded++;
        end
        if (!it.last_in)
            return;
        for (int i = 0; i < loaded; i++)
        begin
            sx = 0;
            sy = 0;
            for (int j = 0; j < loaded; j++)
            begin
                if (j != i)
                begin
                    pair_pull(i, j, fx, fy);
                    sx = sat_q16(sx + fx);
                    sy = sat_q16(sy + fy);
                end
            end
            acc_mem[i][0] = sx;
            acc_mem[i][1] = sy;
        end
        for (int i = 0; i < loaded; i++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                vel_mem[i][k] = sat_q16(vel_mem[i][k] + scale_by_dt(acc_mem[i][k]));
                pos_mem[i][k] = sat_q16(pos_mem[i][k] + scale_by_dt(vel_mem[i][k]));
            end
            r.particle_index = i[5:0];
            r.pos_x_out      = pos_mem[i][0][31:0];
            r.pos_y_out      = pos_mem[i][1][31:0];
            r.vel_x_out      = vel_mem[i][0][31:0];
            r.vel_y_out      = vel_mem[i][1][31:0];
            r.last_out       = (i + 1 == loaded);
            pending_particles.push_back(r);
        end
        loaded = 0;
        step_count++;
    endtask

    // handshake counters, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            in_count <= in_count + 1;
        if (rst_n && cfg_valid && cfg_ready)
            cfg_count <= cfg_count + 1;
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            out_count <= out_count + 1;
            if (pending_particles.size() == 0)
            begin
                $display("%0t: unexpected result item %p", $realtime, out_item);
                error_count++;
            end
            else
            begin
                want = pending_particles.pop_front();
                if (out_item.particle_index !== want.particle_index)
                begin
                    $display("%0t: particle_index expected %0d actual %0d", $realtime,
                             want.particle_index, out_item.particle_index);
                    error_count++;
                end
                if (out_item.pos_x_out !== want.pos_x_out)
                begin
                    $display("%0t: pos_x_out expected %h actual %h", $realtime,
                             want.pos_x_out, out_item.pos_x_out);
                    error_count++;
                end
                if (out_item.pos_y_out !== want.pos_y_out)
                begin
                    $display("%0t: pos_y_out expected %h actual %h", $realtime,
                             want.pos_y_out, out_item.pos_y_out);
                    error_count++;
                end
                if (out_item.vel_x_out !== want.vel_x_out)
                begin
                    $display("%0t: vel_x_out expected %h actual %h", $realtime,
                             want.vel_x_out, out_item.vel_x_out);
                    error_count++;
                end
                if (out_item.vel_y_out !== want.vel_y_out)
                begin
                    $display("%0t: vel_y_out expected %h actual %h", $realtime,
                             want.vel_y_out, out_item.vel_y_out);
                    error_count++;
                end
                if (out_item.last_out !== want.last_out)
                begin
                    $display("%0t: last_out expected %0b actual %0b", $realtime,
                             want.last_out, out_item.last_out);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_particles.size());
            $display("simulation failed");
            $finish;
        end
    end

    // receiver with random stalls
    initial
    begin
        int gap;
        int target;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            target = out_count + 1;
            do @(negedge clk); while (out_count < target);
        end
    end

    // send one item after a random gap, then update the prediction
    task automatic send_particle(input in_item_t it);
        int gap;
        int target;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        target   = in_count + 1;
        do @(negedge clk); while (in_count < target);
        advance_particles(it);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_particles.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        int target;
        drain_results();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        target    = cfg_count + 1;
        do @(negedge clk); while (cfg_count < target);
        cfg_valid = 1'b0;
        box_len   = (idx == CFG_BOX_LENGTH) ? longint'(value[30:0]) : box_len;
        dt        = (idx == CFG_TIME_STEP) ? longint'(value[30:0]) : dt;
    endtask

    function automatic in_item_t make_particle(int px, int py, int vx, int vy, bit last);
        in_item_t it;
        it.pos_x_in = px;
        it.pos_y_in = py;
        it.vel_x_in = vx;
        it.vel_y_in = vy;
        it.last_in  = last;
        return it;
    endfunction

    function automatic out_item_t make_result(int px, int py, int vx, int vy);
        out_item_t r;
        r.particle_index = '0;
        r.pos_x_out      = px;
        r.pos_y_out      = py;
        r.vel_x_out      = vx;
        r.vel_y_out      = vy;
        r.last_out       = 1'b1;
        return r;
    endfunction

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    typedef struct {
        logic [31:0] box;
        logic [31:0] step;
    } cfg_pair_t;

    stim_row_t directed[$];

    // main sequence
    initial
    begin
        stim_row_t row;
        in_item_t  it;
        cfg_pair_t settings[6];
        int set_size;
        int base_x;
        int base_y;
        int random_items;
        int max_int;
        int min_int;

        max_int      = 32'h7FFF_FFFF;
        min_int      = 32'h8000_0000;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_BOX_LENGTH;
        cfg_data     = '0;
        calm         = 1'b0;
        error_count  = 0;
        in_count     = 0;
        out_count    = 0;
        cfg_count    = 0;
        step_count   = 0;
        loaded       = 0;
        box_len      = 1310720;
        dt           = 655;
        random_items = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                pos_mem[i][k] = 0;
                vel_mem[i][k] = 0;
                acc_mem[i][k] = 0;
            end
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed rows; single particles have results readable by hand
        directed.push_back('{make_particle(0, 0, ONE, -ONE, 1), 1,
                             make_result(655, -655, ONE, -ONE)});
        directed.push_back('{make_particle(max_int, max_int, max_int, max_int, 1), 1,
                             make_result(max_int, max_int, max_int, max_int)});
        directed.push_back('{make_particle(min_int, min_int, min_int, min_int, 1), 1,
                             make_result(min_int, min_int, min_int, min_int)});
        directed.push_back('{make_particle(0, 0, 0, 0, 1), 1, make_result(0, 0, 0, 0)});
        // pair one unit apart
        directed.push_back('{make_particle(ONE, ONE, 0, 0, 0), 0, '0});
        directed.push_back('{make_particle(2 * ONE, ONE, 0, 0, 1), 0, '0});
        // coincident pair gives no force
        directed.push_back('{make_particle(3 * ONE, 3 * ONE, 100, -100, 0), 0, '0});
        directed.push_back('{make_particle(3 * ONE, 3 * ONE, -7, 9, 1), 0, '0});
        // pair beyond the cutoff
        directed.push_back('{make_particle(0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{make_particle(5 * ONE, 0, 0, 0, 1), 0, '0});
        // pair far apart inside the box, not wrapped, beyond the cutoff
        directed.push_back('{make_particle(ONE / 2, ONE / 2, 0, 0, 0), 0, '0});
        directed.push_back('{make_particle(9 * ONE + ONE / 2, ONE / 2, 0, 0, 1), 0, '0});
        // one lsb apart, force saturates
        directed.push_back('{make_particle(ONE, ONE, 0, 0, 0), 0, '0});
        directed.push_back('{make_particle(ONE + 1, ONE, 0, 0, 1), 0, '0});
        // three particles in a cluster
        directed.push_back('{make_particle(2 * ONE, 2 * ONE, 500, 0, 0), 0, '0});
        directed.push_back('{make_particle(203162, 2 * ONE, 0, -500, 0), 0, '0});
        directed.push_back('{make_particle(163840, 3 * ONE, -300, 300, 1), 0, '0});
        // y-only pair at negative coordinates
        directed.push_back('{make_particle(-2 * ONE, -3 * ONE, 0, 0, 0), 0, '0});
        directed.push_back('{make_particle(-2 * ONE, -222822, 0, 0, 1), 0, '0});

        foreach (directed[n])
        begin
            row = directed[n];
            send_particle(row.item);
            if (row.typed)
            begin
                void'(pending_particles.pop_back());
                pending_particles.push_back(row.want);
            end
        end

        // random phases, each under its own box length and time step
        settings[0] = '{32'd655360, 32'd655};
        settings[1] = '{32'd0, 32'd655};
        settings[2] = '{32'h7FFF_FFFF, 32'd65536};
        settings[3] = '{32'd327680, 32'd0};
        settings[4] = '{32'd196608, 32'h7FFF_FFFF};
        settings[5] = '{32'h8000_0000 | $urandom_range(2 * ONE, 20 * ONE),
                        32'h8000_0000 | $urandom_range(1, 4000)};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_BOX_LENGTH, settings[p].box);
            write_reg(CFG_TIME_STEP, settings[p].step);
            calm = (p == 2);
            for (int n = 0; n < 65; n += set_size)
            begin
                set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                         : $urandom_range(1, 5);
                base_x = $urandom_range(0, 16 * ONE) - 4 * ONE;
                base_y = $urandom_range(0, 16 * ONE) - 4 * ONE;
                for (int k = 0; k < set_size; k++)
                begin
                    if ($urandom_range(0, 5) == 0)
                        it = make_particle($urandom, $urandom, $urandom, $urandom, 0);
                    else
                        it = make_particle(base_x + $urandom_range(0, 3 * ONE),
                                           base_y + $urandom_range(0, 3 * ONE),
                                           $urandom_range(0, 4 * ONE) - 2 * ONE,
                                           $urandom_range(0, 4 * ONE) - 2 * ONE, 0);
                    it.last_in = (k == set_size - 1);
                    send_particle(it);
                    random_items++;
                end
                // on one set in eight at random, hold the sender until the step has fully drained
                if ($urandom_range(0, 7) == 0)
                    drain_results();
            end
        end

        // fill the store past its depth; spacing keeps every pair beyond cutoff
        write_reg(CFG_BOX_LENGTH, 32'd0);
        write_reg(CFG_TIME_STEP, 32'd655);
        calm = 1'b0;
        for (int k = 0; k < STORE_DEPTH + 2; k++)
        begin
            it = make_particle(k * 3 * ONE, $urandom_range(0, 1000),
                               $urandom_range(0, 2 * ONE) - ONE, 0, k == STORE_DEPTH + 1);
            send_particle(it);
        end

        drain_results();
        $display("covered %0d directed and %0d random items plus a store overflow set,",
                 directed.size(), random_items);
        $display("%0d steps, %0d particles checked, %0d mismatches", step_count, out_count,
                 error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
